### rtl/ptcs_pkg.sv
// shared types, codes and helpers of the port and address traffic classifier
package ptcs_pkg;

	// default sizes
	localparam int MONITORED_PORTS_DEF = 4;
	localparam int LEARNED_ADDRS_DEF   = 16;

	// fixed widths of the register file and the result fields
	localparam int PORT_REGS  = 4;
	localparam int SLOT_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PORT_A   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PORT_B   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PORT_C   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PORT_D   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IN_USE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd5;

	// result line classes
	localparam logic [2:0] CLS_PORT_TX   = 3'd0;
	localparam logic [2:0] CLS_PORT_RX   = 3'd1;
	localparam logic [2:0] CLS_IP_TX     = 3'd2;
	localparam logic [2:0] CLS_IP_RX     = 3'd3;
	localparam logic [2:0] CLS_UNMATCHED = 3'd4;
	localparam logic [2:0] CLS_RPT_TX    = 3'd5;
	localparam logic [2:0] CLS_RPT_RX    = 3'd6;

	localparam logic [SLOT_W-1:0] SLOT_NONE = 3'd4;

	localparam logic [7:0]  SQL_FLAGS      = 8'h18;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] INTERVAL_RESET = 16'd30;

	// which result line the datapath loads into the output register
	typedef enum logic [2:0] {
		LN_PKT    = 3'd0,
		LN_RPT_TX = 3'd1,
		LN_RPT_RX = 3'd2,
		LN_TOT_TX = 3'd3,
		LN_TOT_RX = 3'd4
	} line_t;

	// controller to datapath
	typedef struct packed {
		logic              capture;
		logic              match;
		logic              update;
		logic              emit;
		logic              div_start;
		line_t             line;
		logic [SLOT_W-1:0] slot;
	} ptcs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic              out_free;
		logic              div_done;
		logic [SLOT_W-1:0] slots_used;
	} ptcs_sts_t;

	// saturating packet count
	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// saturating byte count
	function automatic logic [47:0] sat_add48(input logic [47:0] v, input logic [15:0] len);
		logic [48:0] sum;
		sum = {1'b0, v} + {33'd0, len};
		return sum[48] ? '1 : sum[47:0];
	endfunction

	function automatic logic [15:0] max16(input logic [15:0] a, input logic [15:0] b);
		return (a < b) ? b : a;
	endfunction

endpackage

### rtl/ptcs_div.sv
// iterative 32 by 16 bit unsigned divider, one quotient bit per cycle
module ptcs_div import ptcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] rem_shift;
	logic        fits;

	// restoring step
	assign rem_shift = {rem_q, quo_q[31]};
	assign fits      = rem_shift >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(rem_shift - {1'b0, dvs_q}) : rem_shift[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/ptcs_dp.sv
// datapath: config registers, match logic, counters, address table, output register
module ptcs_dp import ptcs_pkg::*; #(
	parameter int MONITORED_PORTS = MONITORED_PORTS_DEF,
	parameter int LEARNED_ADDRS   = LEARNED_ADDRS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [7:0]            protocol,
	input  logic [15:0]           src_port,
	input  logic [15:0]           dst_port,
	input  logic [7:0]            tcp_flags,
	input  logic [31:0]           src_addr,
	input  logic [31:0]           dst_addr,
	input  logic [15:0]           wire_length,
	input  ptcs_cmd_t             cmd_i,
	output ptcs_sts_t             sts_o,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [2:0]            line_class,
	output logic [SLOT_W-1:0]     slot,
	output logic [31:0]           packet_count,
	output logic [47:0]           byte_total,
	output logic [15:0]           largest_packet,
	output logic [31:0]           sql_count,
	output logic [47:0]           sql_bytes,
	output logic [31:0]           sql_rate,
	output logic                  last
);

	localparam int IDX_W  = (MONITORED_PORTS > 1) ? $clog2(MONITORED_PORTS) : 1;
	localparam int AIDX_W = (LEARNED_ADDRS > 1) ? $clog2(LEARNED_ADDRS) : 1;
	localparam int FILL_W = $clog2(LEARNED_ADDRS + 1);

	// config registers
	logic [15:0] port_q [PORT_REGS];
	logic [2:0]  in_use_q;
	logic [15:0] interval_q;
	logic [SLOT_W-1:0] used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORT_REGS; i++) port_q[i] <= '0;
			in_use_q   <= '0;
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PORT_A:   port_q[0]  <= cfg_data;
				REG_PORT_B:   port_q[1]  <= cfg_data;
				REG_PORT_C:   port_q[2]  <= cfg_data;
				REG_PORT_D:   port_q[3]  <= cfg_data;
				REG_IN_USE:   in_use_q   <= cfg_data[2:0];
				REG_INTERVAL: interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign used = (in_use_q > SLOT_W'(MONITORED_PORTS)) ? SLOT_W'(MONITORED_PORTS) : in_use_q;

	// captured packet header
	logic [15:0] sport_q, dport_q, len_q;
	logic [31:0] saddr_q, daddr_q;
	logic        sql_pkt_q;

	always_ff @(posedge clk) begin
		if (cmd_i.capture) begin
			sport_q   <= src_port;
			dport_q   <= dst_port;
			saddr_q   <= src_addr;
			daddr_q   <= dst_addr;
			len_q     <= wire_length;
			sql_pkt_q <= (protocol != PROTO_UDP) && (tcp_flags == SQL_FLAGS);
		end
	end

	// learned address table, filled in order
	logic [31:0]       addr_mem [LEARNED_ADDRS];
	logic [FILL_W-1:0] fill_q;

	// parallel compares against the port slots and the address table
	logic             src_hit, dst_hit, src_known, dst_known;
	logic [IDX_W-1:0] src_idx, dst_idx;

	always_comb begin
		src_hit = 1'b0;
		dst_hit = 1'b0;
		src_idx = '0;
		dst_idx = '0;
		for (int i = 0; i < MONITORED_PORTS; i++) begin
			if (!src_hit && SLOT_W'(i) < used && port_q[i] == sport_q) begin
				src_hit = 1'b1;
				src_idx = IDX_W'(i);
			end
			if (!dst_hit && SLOT_W'(i) < used && port_q[i] == dport_q) begin
				dst_hit = 1'b1;
				dst_idx = IDX_W'(i);
			end
		end
		src_known = 1'b0;
		dst_known = 1'b0;
		for (int j = 0; j < LEARNED_ADDRS; j++) begin
			if (FILL_W'(j) < fill_q && addr_mem[j] == saddr_q) src_known = 1'b1;
			if (FILL_W'(j) < fill_q && addr_mem[j] == daddr_q) dst_known = 1'b1;
		end
	end

	// registered classification
	logic [2:0]       cls_q;
	logic [IDX_W-1:0] idx_q;
	logic             learn_q;

	always_ff @(posedge clk) begin
		if (cmd_i.match) begin
			learn_q <= 1'b0;
			idx_q   <= '0;
			if (src_hit) begin
				cls_q <= CLS_PORT_TX;
				idx_q <= src_idx;
			end else if (dst_hit) begin
				cls_q   <= CLS_PORT_RX;
				idx_q   <= dst_idx;
				learn_q <= !dst_known;
			end else if (src_known) begin
				cls_q <= CLS_IP_TX;
			end else if (dst_known) begin
				cls_q <= CLS_IP_RX;
			end else begin
				cls_q <= CLS_UNMATCHED;
			end
		end
	end

	// address learning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd_i.update && learn_q && fill_q < FILL_W'(LEARNED_ADDRS)) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.update && learn_q && fill_q < FILL_W'(LEARNED_ADDRS)) begin
			addr_mem[fill_q[AIDX_W-1:0]] <= daddr_q;
		end
	end

	// counters
	logic [31:0] tx_pk_q [MONITORED_PORTS];
	logic [47:0] tx_by_q [MONITORED_PORTS];
	logic [15:0] tx_lg_q [MONITORED_PORTS];
	logic [31:0] rx_pk_q [MONITORED_PORTS];
	logic [47:0] rx_by_q [MONITORED_PORTS];
	logic [15:0] rx_lg_q [MONITORED_PORTS];
	logic [31:0] sq_pk_q [MONITORED_PORTS];
	logic [47:0] sq_by_q [MONITORED_PORTS];
	logic [31:0] ttx_pk_q, trx_pk_q;
	logic [47:0] ttx_by_q, trx_by_q;
	logic [15:0] ttx_lg_q, trx_lg_q;
	logic        clear;

	assign clear = cmd_i.emit && cmd_i.line == LN_TOT_RX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MONITORED_PORTS; i++) begin
				tx_pk_q[i] <= '0; tx_by_q[i] <= '0; tx_lg_q[i] <= '0;
				rx_pk_q[i] <= '0; rx_by_q[i] <= '0; rx_lg_q[i] <= '0;
				sq_pk_q[i] <= '0; sq_by_q[i] <= '0;
			end
			ttx_pk_q <= '0; ttx_by_q <= '0; ttx_lg_q <= '0;
			trx_pk_q <= '0; trx_by_q <= '0; trx_lg_q <= '0;
		end else if (clear) begin
			for (int i = 0; i < MONITORED_PORTS; i++) begin
				tx_pk_q[i] <= '0; tx_by_q[i] <= '0; tx_lg_q[i] <= '0;
				rx_pk_q[i] <= '0; rx_by_q[i] <= '0; rx_lg_q[i] <= '0;
				sq_pk_q[i] <= '0; sq_by_q[i] <= '0;
			end
			ttx_pk_q <= '0; ttx_by_q <= '0; ttx_lg_q <= '0;
			trx_pk_q <= '0; trx_by_q <= '0; trx_lg_q <= '0;
		end else if (cmd_i.update) begin
			case (cls_q)
				CLS_PORT_TX: begin
					tx_pk_q[idx_q] <= sat_inc32(tx_pk_q[idx_q]);
					tx_by_q[idx_q] <= sat_add48(tx_by_q[idx_q], len_q);
					tx_lg_q[idx_q] <= max16(tx_lg_q[idx_q], len_q);
				end
				CLS_PORT_RX: begin
					rx_pk_q[idx_q] <= sat_inc32(rx_pk_q[idx_q]);
					rx_by_q[idx_q] <= sat_add48(rx_by_q[idx_q], len_q);
					rx_lg_q[idx_q] <= max16(rx_lg_q[idx_q], len_q);
					if (sql_pkt_q) begin
						sq_pk_q[idx_q] <= sat_inc32(sq_pk_q[idx_q]);
						sq_by_q[idx_q] <= sat_add48(sq_by_q[idx_q], len_q);
					end
				end
				default: ;
			endcase
			case (cls_q)
				CLS_PORT_TX, CLS_IP_TX: begin
					ttx_pk_q <= sat_inc32(ttx_pk_q);
					ttx_by_q <= sat_add48(ttx_by_q, len_q);
					ttx_lg_q <= max16(ttx_lg_q, len_q);
				end
				CLS_PORT_RX, CLS_IP_RX: begin
					trx_pk_q <= sat_inc32(trx_pk_q);
					trx_by_q <= sat_add48(trx_by_q, len_q);
					trx_lg_q <= max16(trx_lg_q, len_q);
				end
				default: ;
			endcase
		end
	end

	// sql rate divider
	logic [IDX_W-1:0] ridx;
	logic [31:0]      quotient;
	logic             div_done;

	assign ridx = cmd_i.slot[IDX_W-1:0];

	ptcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd_i.div_start),
		.dividend (sq_pk_q[ridx]),
		.divisor  ((interval_q == '0) ? 16'd1 : interval_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// output register
	logic              ov_q;
	logic [2:0]        cls_o_q;
	logic [SLOT_W-1:0] slot_o_q;
	logic [31:0]       pk_o_q, sqc_o_q, rate_o_q;
	logic [47:0]       by_o_q, sqb_o_q;
	logic [15:0]       lg_o_q;
	logic              last_o_q;
	logic              out_free;

	assign out_free = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd_i.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.emit) begin
			sqc_o_q  <= '0;
			sqb_o_q  <= '0;
			rate_o_q <= '0;
			last_o_q <= 1'b0;
			slot_o_q <= cmd_i.slot;
			case (cmd_i.line)
				LN_RPT_TX: begin
					cls_o_q <= CLS_RPT_TX;
					pk_o_q  <= tx_pk_q[ridx];
					by_o_q  <= tx_by_q[ridx];
					lg_o_q  <= tx_lg_q[ridx];
				end
				LN_RPT_RX: begin
					cls_o_q  <= CLS_RPT_RX;
					pk_o_q   <= rx_pk_q[ridx];
					by_o_q   <= rx_by_q[ridx];
					lg_o_q   <= rx_lg_q[ridx];
					sqc_o_q  <= sq_pk_q[ridx];
					sqb_o_q  <= sq_by_q[ridx];
					rate_o_q <= quotient;
				end
				LN_TOT_TX: begin
					cls_o_q  <= CLS_RPT_TX;
					slot_o_q <= SLOT_NONE;
					pk_o_q   <= ttx_pk_q;
					by_o_q   <= ttx_by_q;
					lg_o_q   <= ttx_lg_q;
				end
				LN_TOT_RX: begin
					cls_o_q  <= CLS_RPT_RX;
					slot_o_q <= SLOT_NONE;
					pk_o_q   <= trx_pk_q;
					by_o_q   <= trx_by_q;
					lg_o_q   <= trx_lg_q;
					last_o_q <= 1'b1;
				end
				default: begin
					cls_o_q  <= cls_q;
					slot_o_q <= (cls_q == CLS_PORT_TX || cls_q == CLS_PORT_RX) ?
						SLOT_W'(idx_q) : SLOT_NONE;
					pk_o_q   <= '0;
					by_o_q   <= '0;
					lg_o_q   <= '0;
					last_o_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid      = ov_q;
	assign line_class     = cls_o_q;
	assign slot           = slot_o_q;
	assign packet_count   = pk_o_q;
	assign byte_total     = by_o_q;
	assign largest_packet = lg_o_q;
	assign sql_count      = sqc_o_q;
	assign sql_bytes      = sqb_o_q;
	assign sql_rate       = rate_o_q;
	assign last           = last_o_q;

	assign sts_o.out_free   = out_free;
	assign sts_o.div_done   = div_done;
	assign sts_o.slots_used = used;

endmodule

### rtl/ptcs_ctrl.sv
// controller: sequences packet classification and report lines
module ptcs_ctrl import ptcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_cmd,
	output logic      in_ready,
	input  ptcs_sts_t sts_i,
	output ptcs_cmd_t cmd_o
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_MATCH  = 10'b0000000010,
		ST_UPDATE = 10'b0000000100,
		ST_EMIT   = 10'b0000001000,
		ST_RPT_TX = 10'b0000010000,
		ST_RPT_DV = 10'b0000100000,
		ST_RPT_RX = 10'b0001000000,
		ST_TOT_TX = 10'b0010000000,
		ST_TOT_RX = 10'b0100000000,
		ST_SPARE  = 10'b1000000000
	} state_t;

	state_t            state_q, state_d;
	logic [SLOT_W-1:0] slot_q, slot_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		slot_d  = slot_q;
		cmd_o   = '0;
		cmd_o.line = LN_PKT;
		cmd_o.slot = slot_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_o.capture = 1'b1;
					slot_d = '0;
					if (!in_cmd) state_d = ST_MATCH;
					else if (sts_i.slots_used == '0) state_d = ST_TOT_TX;
					else state_d = ST_RPT_TX;
				end
			end
			ST_MATCH: begin
				cmd_o.match = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd_o.update = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts_i.out_free) begin
					cmd_o.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RPT_TX: begin
				cmd_o.line = LN_RPT_TX;
				if (sts_i.out_free) begin
					cmd_o.emit = 1'b1;
					cmd_o.div_start = 1'b1;
					state_d = ST_RPT_DV;
				end
			end
			ST_RPT_DV: begin
				if (sts_i.div_done) state_d = ST_RPT_RX;
			end
			ST_RPT_RX: begin
				cmd_o.line = LN_RPT_RX;
				if (sts_i.out_free) begin
					cmd_o.emit = 1'b1;
					if (slot_q == sts_i.slots_used - SLOT_W'(1)) begin
						state_d = ST_TOT_TX;
					end else begin
						slot_d  = slot_q + SLOT_W'(1);
						state_d = ST_RPT_TX;
					end
				end
			end
			ST_TOT_TX: begin
				cmd_o.line = LN_TOT_TX;
				if (sts_i.out_free) begin
					cmd_o.emit = 1'b1;
					state_d = ST_TOT_RX;
				end
			end
			ST_TOT_RX: begin
				cmd_o.line = LN_TOT_RX;
				if (sts_i.out_free) begin
					cmd_o.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
		end
	end

	// a line is loaded only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.emit |-> sts_i.out_free) else $error("emit into full output register");

	// the interface RX line closes a report
	a_tot_rx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_o.emit && cmd_o.line == LN_TOT_RX) |=> state_q == ST_IDLE)
		else $error("report did not end after totals");

	// a port RX line follows a finished division
	a_div_before_rx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RPT_DV && sts_i.div_done) |=> state_q == ST_RPT_RX)
		else $error("port RX line not reached after division");

	// the slot counter never leaves the slots in use during a report
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RPT_TX || state_q == ST_RPT_RX) |-> slot_q < sts_i.slots_used)
		else $error("report slot out of range");

endmodule

### rtl/port_ip_traffic_classifier_stats.sv
// top level of the port and address traffic classifier with interval statistics
//
// A packet transfer goes from acceptance to its single result through capture, parallel port
// and address compare, counter read-modify-write and load of the output register. A report
// transfer gives two lines per monitored port in use and two interface total lines; each port
// RX line waits on a bit-serial divider for the SQL rate. One item is worked at a time; the
// output register lets the next item be accepted while the last result waits to be taken. A
// report clears all counters but keeps the learned address table.
module port_ip_traffic_classifier_stats import ptcs_pkg::*; #(
	parameter int MONITORED_PORTS = MONITORED_PORTS_DEF,
	parameter int LEARNED_ADDRS   = LEARNED_ADDRS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [7:0]            protocol,
	input  logic [15:0]           src_port,
	input  logic [15:0]           dst_port,
	input  logic [7:0]            tcp_flags,
	input  logic [31:0]           src_addr,
	input  logic [31:0]           dst_addr,
	input  logic [15:0]           wire_length,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            line_class,
	output logic [SLOT_W-1:0]     slot,
	output logic [31:0]           packet_count,
	output logic [47:0]           byte_total,
	output logic [15:0]           largest_packet,
	output logic [31:0]           sql_count,
	output logic [47:0]           sql_bytes,
	output logic [31:0]           sql_rate,
	output logic                  last
);

	ptcs_cmd_t cmd_w;
	ptcs_sts_t sts_w;

	// sequencing
	ptcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (cmd),
		.in_ready (in_ready),
		.sts_i    (sts_w),
		.cmd_o    (cmd_w)
	);

	// storage and arithmetic
	ptcs_dp #(
		.MONITORED_PORTS (MONITORED_PORTS),
		.LEARNED_ADDRS   (LEARNED_ADDRS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.protocol       (protocol),
		.src_port       (src_port),
		.dst_port       (dst_port),
		.tcp_flags      (tcp_flags),
		.src_addr       (src_addr),
		.dst_addr       (dst_addr),
		.wire_length    (wire_length),
		.cmd_i          (cmd_w),
		.sts_o          (sts_w),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.line_class     (line_class),
		.slot           (slot),
		.packet_count   (packet_count),
		.byte_total     (byte_total),
		.largest_packet (largest_packet),
		.sql_count      (sql_count),
		.sql_bytes      (sql_bytes),
		.sql_rate       (sql_rate),
		.last           (last)
	);

endmodule
